[rtl/core/trp_pkg.sv]
// Shared types, codes and constants of the transmit ring packetizer.
// No dependencies; imported by trp_core, tx_ring_packetizer, trp_checker and the bench.
package trp_pkg;

    // ring size default and packet length ceiling
    localparam int BUFFER_DEPTH_DEF = 256;
    localparam logic [7:0] PACKET_CAP = 8'd128;

    // register reset values
    localparam logic [7:0] MAX_PACKET_RST      = 8'd128;
    localparam logic [8:0] EARLY_THRESHOLD_RST = 9'd64;
    localparam logic [7:0] LATENCY_FRAMES_RST  = 8'd8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EARLY_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LATENCY_FRAMES  = 2'd2;

    // item kinds carried in tuser
    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_TX_DONE = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;
    localparam logic [1:0] MODE_READ    = 2'd3;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [7:0] read_index;
        logic       link_ready;
    } t_item;

    // result fields except the stored byte, which comes from the ring memory
    typedef struct packed {
        logic       accepted;
        logic       send_start;
        logic [7:0] send_offset;
        logic [7:0] send_length;
        logic [8:0] free_space;
        logic       all_sent;
    } t_result;

endpackage

[rtl/core/trp_core.sv]
// Ring state, byte memory and packet launch decision of the packetizer.
// Depends on trp_pkg.
module trp_core #(
    parameter int BUFFER_DEPTH = trp_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [trp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [trp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_en,
    input  trp_pkg::t_item                 i_item,
    output trp_pkg::t_result               o_result,
    output logic [7:0]                     o_read_data
);
    import trp_pkg::*;

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam int FW = PW + 1;

    logic [7:0]    r_mem [BUFFER_DEPTH];
    logic [7:0]    r_read_data;

    logic [PW-1:0] r_rp, n_rp;
    logic [PW-1:0] r_wp, n_wp;
    logic [FW-1:0] r_fill, n_fill;
    logic [7:0]    r_flight, n_flight;
    logic [7:0]    r_idle, n_idle;

    logic [7:0]    r_max_packet;
    logic [8:0]    r_early_threshold;
    logic [7:0]    r_latency_frames;

    logic          w_wr;
    logic          w_launch;
    logic          w_release;
    logic          w_acc;
    logic [7:0]    w_cap;
    logic [FW-1:0] w_to_wrap;
    logic [FW-1:0] w_len_a;
    logic [FW-1:0] w_len_b;
    logic [7:0]    w_len;

    // clamp the packet cap into 1..128
    always_comb begin
        if (r_max_packet == '0) begin
            w_cap = 8'd1;
        end else if (r_max_packet > PACKET_CAP) begin
            w_cap = PACKET_CAP;
        end else begin
            w_cap = r_max_packet;
        end
    end

    always_comb begin
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_fill    = r_fill;
        n_idle    = r_idle;
        w_wr      = 1'b0;
        w_launch  = 1'b0;
        w_release = 1'b0;
        w_acc     = 1'b0;
        case (i_item.mode)
            MODE_WRITE: begin
                if (i_item.link_ready) begin
                    if (r_fill != FW'(BUFFER_DEPTH)) begin
                        w_wr   = 1'b1;
                        w_acc  = 1'b1;
                        n_wp   = r_wp + 1'b1;
                        n_fill = r_fill + 1'b1;
                    end
                    if (i_item.last_byte && r_flight == '0 && n_fill != '0 &&
                        n_fill >= r_early_threshold) begin
                        w_launch = 1'b1;
                    end
                end
            end
            MODE_TX_DONE: begin
                n_idle = '0;
                if (r_flight != '0) begin
                    w_release = 1'b1;
                    n_rp      = r_rp + PW'(r_flight);
                    n_fill    = (r_fill > FW'(r_flight)) ? r_fill - FW'(r_flight) : '0;
                    if (i_item.link_ready) begin
                        w_launch = (n_fill != '0);
                    end else begin
                        // link lost: drop everything buffered
                        n_fill = '0;
                        n_rp   = r_wp;
                    end
                end
            end
            MODE_TICK: begin
                if (r_fill != '0 && r_flight == '0) begin
                    n_idle   = (r_idle == 8'hFF) ? r_idle : r_idle + 1'b1;
                    w_launch = (n_idle >= r_latency_frames);
                end
            end
            default: begin
            end
        endcase
    end

    // packet length: min of fill, bytes to ring end and cap
    always_comb begin
        w_to_wrap = FW'(BUFFER_DEPTH) - {1'b0, n_rp};
        w_len_a   = (n_fill < w_to_wrap) ? n_fill : w_to_wrap;
        w_len_b   = (w_len_a < FW'(w_cap)) ? w_len_a : FW'(w_cap);
        w_len     = 8'(w_len_b);
    end

    always_comb begin
        if (w_launch) begin
            n_flight = w_len;
        end else if (w_release) begin
            n_flight = '0;
        end else begin
            n_flight = r_flight;
        end
    end

    always_comb begin
        o_result.accepted    = w_acc;
        o_result.send_start  = w_launch;
        o_result.send_offset = w_launch ? 8'(n_rp) : 8'd0;
        o_result.send_length = w_launch ? w_len : 8'd0;
        o_result.free_space  = i_item.link_ready ? 9'(FW'(BUFFER_DEPTH) - n_fill) : 9'd0;
        o_result.all_sent    = (n_fill == '0) && (n_flight == '0);
    end

    assign o_read_data = r_read_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp     <= '0;
            r_wp     <= '0;
            r_fill   <= '0;
            r_flight <= '0;
            r_idle   <= '0;
        end else if (i_en) begin
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_fill   <= n_fill;
            r_flight <= n_flight;
            r_idle   <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_packet      <= MAX_PACKET_RST;
            r_early_threshold <= EARLY_THRESHOLD_RST;
            r_latency_frames  <= LATENCY_FRAMES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_PACKET:      r_max_packet      <= i_cfg_wdata[7:0];
                CFG_EARLY_THRESHOLD: r_early_threshold <= i_cfg_wdata;
                CFG_LATENCY_FRAMES:  r_latency_frames  <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // ring memory: one write or one registered read per item
    always_ff @(posedge i_clk) begin
        if (i_en && w_wr) begin
            r_mem[r_wp] <= i_item.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_item.mode == MODE_READ) begin
                r_read_data <= r_mem[PW'(i_item.read_index)];
            end else begin
                r_read_data <= '0;
            end
        end
    end

endmodule

[rtl/core/tx_ring_packetizer.sv]
// Top level of the transmit ring packetizer: stream handshake and pipeline.
// Depends on trp_pkg and trp_core.
//
//  channel   dir  tdata (low bit up)                          tuser  tlast
//  s_axis    in   data_byte, read_index, link_ready, pad      mode   last_byte
//  m_axis    out  accepted, send_start, send_offset,          -      -
//                 send_length, free_space, all_sent,
//                 read_data, pad
//  cfg       in   i_cfg_we / i_cfg_idx / i_cfg_wdata, no read-back
//
// One beat per cycle in and out while m_axis does not stall. A beat lands in
// the input register; all ring work (write, launch, release, read) goes from
// there into the result register. The ring memory port takes one write or
// one read per beat. Synchronous reset clears pointers, counts and valid
// flags and loads config reset values; ring contents stay undefined. When
// m_axis stalls, the input register fills and then s_axis_tready drops.
module tx_ring_packetizer #(
    parameter int BUFFER_DEPTH = trp_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [trp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [trp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // input items
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] data_byte, [15:8] read_index, [16] link_ready, [23:17] zero
    input  logic [trp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]                     s_axis_tuser,
    input  logic                           s_axis_tlast,
    // results
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] accepted, [1] send_start, [9:2] send_offset, [17:10] send_length,
    // [26:18] free_space, [27] all_sent, [35:28] read_data, [39:36] zero
    output logic [trp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import trp_pkg::*;

    logic       r_in_valid;
    t_item      r_in;
    logic       r_out_valid;
    t_result    r_res;
    t_result    w_res;
    logic [7:0] w_read_data;
    logic       w_adv;
    logic       w_s_fire;

    // advance the input register whenever the result register is free
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_s_fire      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // capture the beat; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_in.mode       <= s_axis_tuser;
            r_in.data_byte  <= s_axis_tdata[7:0];
            r_in.last_byte  <= s_axis_tlast;
            r_in.read_index <= s_axis_tdata[15:8];
            r_in.link_ready <= s_axis_tdata[16];
        end
    end

    trp_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_en        (w_adv),
        .i_item      (r_in),
        .o_result    (w_res),
        .o_read_data (w_read_data)
    );

    // hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, w_read_data, r_res.all_sent, r_res.free_space,
                            r_res.send_length, r_res.send_offset, r_res.send_start,
                            r_res.accepted};

endmodule

[rtl/core/trp_checker.sv]
// Port-level checks of the transmit ring packetizer result stream.
// Depends on trp_pkg; bound to tx_ring_packetizer at the end of this file.
module trp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_m_tvalid,
    input logic                          i_m_tready,
    input logic [trp_pkg::M_TDATA_W-1:0] i_m_tdata
);
    import trp_pkg::*;

    // a result beat waits until it is taken
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("result beat dropped while stalled");

    // a launched packet carries 1..128 bytes
    a_launch_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[1] |-> i_m_tdata[17:10] != 8'd0 &&
        i_m_tdata[17:10] <= PACKET_CAP)
        else $error("launched packet length out of range");

    // no launch means no offset and no length
    a_no_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tdata[1] |-> i_m_tdata[17:2] == 16'd0)
        else $error("offset or length without a launch");

    // a stored byte leaves the ring non-empty
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[0] |-> !i_m_tdata[27])
        else $error("all_sent after a stored byte");

    // reset empties the result stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind tx_ring_packetizer trp_checker u_trp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

[dv/tx_ring_packetizer_tb.sv]
// Self-checking bench for tx_ring_packetizer: directed plan, then random phases.
// Depends on trp_pkg and the RTL top; stand-alone predictor, no file I/O.
`timescale 1ns / 100ps

module tx_ring_packetizer_tb;
    import trp_pkg::*;

    localparam int DEPTH       = BUFFER_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 230;

    // expected beat: packed result fields plus the fetched byte
    typedef struct packed {
        t_result    res;
        logic [7:0] rdata;
    } t_beat_out;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        t_item                  it;
        bit                     typed;
        t_beat_out              want;
        logic [CFG_IDX_W-1:0]   reg_idx;
        int                     reg_val;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    tx_ring_packetizer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Ring predictor state. Pointers and counts are plain ints, wrapped by
    // hand; the shadow store tracks which positions hold a real byte so
    // that reads never touch a position the block has not written.
    // ---------------------------------------------------------------------
    logic [7:0] ring_mem [DEPTH];
    bit         written  [DEPTH];
    bit         any_written = 1'b0;
    int         last_wr_pos = 0;
    int         rd_ptr = 0, wr_ptr = 0, fill = 0, inflight = 0, idle_ticks = 0;
    int         cfg_max = MAX_PACKET_RST;
    int         cfg_thr = EARLY_THRESHOLD_RST;
    int         cfg_lat = LATENCY_FRAMES_RST;

    t_beat_out  pending_beats[$];
    int         errors = 0;
    int         cycles = 0;
    bit         calm = 1'b0;    // no idling on either side while set

    // Launch a packet from the oldest bytes: min of fill, bytes to the wrap
    // point, and the clamped packet cap.
    function automatic void start_packet(inout t_beat_out o);
        int len;
        int cap;
        len = fill;
        cap = cfg_max;
        if (cap == 0) cap = 1;
        if (cap > PACKET_CAP) cap = PACKET_CAP;
        if (len > DEPTH - rd_ptr) len = DEPTH - rd_ptr;
        if (len > cap) len = cap;
        inflight = len;
        o.res.send_start  = 1'b1;
        o.res.send_offset = 8'(rd_ptr);
        o.res.send_length = 8'(len);
    endfunction

    // Advance the predictor by one accepted input beat.
    function automatic t_beat_out ring_predict(input t_item it);
        t_beat_out o;
        o = '0;
        case (it.mode)
            MODE_WRITE: begin
                if (it.link_ready) begin
                    if (fill < DEPTH) begin
                        ring_mem[wr_ptr] = it.data_byte;
                        written[wr_ptr]  = 1'b1;
                        any_written      = 1'b1;
                        last_wr_pos      = wr_ptr;
                        wr_ptr           = (wr_ptr + 1) % DEPTH;
                        fill++;
                        o.res.accepted   = 1'b1;
                    end
                    // a refused write on a full ring still runs the check
                    if (it.last_byte && inflight == 0 && fill != 0 && fill >= cfg_thr)
                        start_packet(o);
                end
            end
            MODE_TX_DONE: begin
                idle_ticks = 0;
                if (inflight != 0) begin
                    rd_ptr   = (rd_ptr + inflight) % DEPTH;
                    fill     = (fill > inflight) ? fill - inflight : 0;
                    inflight = 0;
                    if (it.link_ready) begin
                        if (fill != 0) start_packet(o);
                    end else begin
                        // link lost: drop everything still buffered
                        fill   = 0;
                        rd_ptr = wr_ptr;
                    end
                end
            end
            MODE_TICK: begin
                if (fill != 0 && inflight == 0) begin
                    if (idle_ticks < 255) idle_ticks++;
                    if (idle_ticks >= cfg_lat) start_packet(o);
                end
            end
            default: o.rdata = ring_mem[it.read_index];
        endcase
        o.res.free_space = it.link_ready ? 9'(DEPTH - fill) : 9'd0;
        o.res.all_sent   = (fill == 0 && inflight == 0);
        return o;
    endfunction

    // ---------------------------------------------------------------------
    // Directed plan helpers
    // ---------------------------------------------------------------------
    function automatic t_plan_row item_row(logic [1:0] m, logic [7:0] d, logic l,
                                           logic [7:0] r, logic k);
        t_plan_row row;
        row = '{kind: ROW_ITEM, default: '0};
        row.kind = ROW_ITEM;
        row.it.mode = m;
        row.it.data_byte = d;
        row.it.last_byte = l;
        row.it.read_index = r;
        row.it.link_ready = k;
        return row;
    endfunction

    function automatic t_plan_row typed_row(logic [1:0] m, logic [7:0] d, logic l,
                                            logic [7:0] r, logic k, logic acc,
                                            logic start, logic [7:0] off,
                                            logic [7:0] len, logic [8:0] free,
                                            logic all, logic [7:0] rd);
        t_plan_row row;
        row = item_row(m, d, l, r, k);
        row.typed = 1'b1;
        row.want.res.accepted    = acc;
        row.want.res.send_start  = start;
        row.want.res.send_offset = off;
        row.want.res.send_length = len;
        row.want.res.free_space  = free;
        row.want.res.all_sent    = all;
        row.want.rdata           = rd;
        return row;
    endfunction

    function automatic t_plan_row cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
        t_plan_row row;
        row = '{kind: ROW_CFG, default: '0};
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Pick a ring position that holds a written byte.
    function automatic logic [7:0] pick_read_index();
        int idx;
        repeat (16) begin
            idx = $urandom_range(0, DEPTH - 1);
            if (written[idx]) return 8'(idx);
        end
        return 8'(last_wr_pos);
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // Hold the sender off until every expected result beat has come back.
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (pending_beats.size() != 0) @(negedge i_clk);
    endtask

    // Register write on an idle block; mirror it into the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = CFG_DATA_W'(val);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        case (idx)
            CFG_MAX_PACKET:      cfg_max = val & 8'hFF;
            CFG_EARLY_THRESHOLD: cfg_thr = val & 9'h1FF;
            CFG_LATENCY_FRAMES:  cfg_lat = val & 8'hFF;
            default: ;
        endcase
    endtask

    // Drive one input beat (entered and left at a falling edge), wait for the
    // handshake, then queue its expected result.
    task automatic push_beat(input t_item it, input bit typed, input t_beat_out want);
        int gap;
        t_beat_out o;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {7'b0, it.link_ready, it.read_index, it.data_byte};
        s_axis_tuser  = it.mode;
        s_axis_tlast  = it.last_byte;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        o = ring_predict(it);
        pending_beats.push_back(typed ? want : o);
        @(negedge i_clk);
    endtask

    task automatic send_random(input t_item it);
        push_beat(it, 1'b0, '0);
    endtask

    // ---------------------------------------------------------------------
    // Result side: random stalls, compare each beat field by field against
    // the oldest expectation.
    // ---------------------------------------------------------------------
    initial begin : result_stall
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall--;
            end else begin
                m_axis_tready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : check_beat
        t_beat_out w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_beats.size() == 0) begin
                report("unexpected beat", 64'(m_axis_tdata), 64'd0);
            end else begin
                w = pending_beats.pop_front();
                if (m_axis_tdata[0] !== w.res.accepted)
                    report("accepted", 64'(m_axis_tdata[0]), 64'(w.res.accepted));
                if (m_axis_tdata[1] !== w.res.send_start)
                    report("send_start", 64'(m_axis_tdata[1]), 64'(w.res.send_start));
                if (m_axis_tdata[9:2] !== w.res.send_offset)
                    report("send_offset", 64'(m_axis_tdata[9:2]),
                           64'(w.res.send_offset));
                if (m_axis_tdata[17:10] !== w.res.send_length)
                    report("send_length", 64'(m_axis_tdata[17:10]),
                           64'(w.res.send_length));
                if (m_axis_tdata[26:18] !== w.res.free_space)
                    report("free_space", 64'(m_axis_tdata[26:18]),
                           64'(w.res.free_space));
                if (m_axis_tdata[27] !== w.res.all_sent)
                    report("all_sent", 64'(m_axis_tdata[27]), 64'(w.res.all_sent));
                if (m_axis_tdata[35:28] !== w.rdata)
                    report("read_data", 64'(m_axis_tdata[35:28]), 64'(w.rdata));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tx_ring_packetizer_tb NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin : stimulus
        t_plan_row   plan[$];
        t_item       it;
        int          unsigned pmax[5];
        int          unsigned pthr[5];
        int          unsigned plat[5];
        int          sent;
        int          r;
        int          n;
        logic        k;

        pmax = '{128, 1, 255, 0, 7};
        pthr = '{64, 1, 256, 0, 511};
        plat = '{8, 1, 255, 0, 3};

        // Directed plan. Rows with a typed result cover reset state, refused
        // writes, a launch that can be read off directly and the link-down
        // drop; the rest go through the predictor.
        plan.push_back(typed_row(MODE_TICK,    8'h00, 0, 8'h00, 1, 0, 0, 0, 0, 256, 1, 0));
        plan.push_back(typed_row(MODE_TX_DONE, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0, 0, 1, 0));
        plan.push_back(typed_row(MODE_WRITE,   8'hFF, 1, 8'hFF, 0, 0, 0, 0, 0, 0, 1, 0));
        plan.push_back(typed_row(MODE_WRITE,   8'h00, 0, 8'h00, 1, 1, 0, 0, 0, 255, 0, 0));
        plan.push_back(typed_row(MODE_WRITE,   8'hFF, 1, 8'h00, 1, 1, 0, 0, 0, 254, 0, 0));
        plan.push_back(typed_row(MODE_READ,    8'hFF, 1, 8'h00, 1, 0, 0, 0, 0, 254, 0, 8'h00));
        plan.push_back(typed_row(MODE_READ,    8'h00, 0, 8'h01, 0, 0, 0, 0, 0, 0, 0, 8'hFF));
        plan.push_back(item_row(MODE_TICK, 8'h00, 0, 8'h00, 1));
        plan.push_back(cfg_row(CFG_LATENCY_FRAMES, 0));
        // zero latency: the next tick with bytes waiting launches at once
        plan.push_back(typed_row(MODE_TICK,    8'h00, 0, 8'h00, 0, 0, 1, 0, 2, 0, 0, 0));
        plan.push_back(item_row(MODE_TICK,    8'h00, 0, 8'h00, 1));
        plan.push_back(item_row(MODE_WRITE,   8'h3C, 1, 8'h00, 1));
        plan.push_back(item_row(MODE_TX_DONE, 8'h00, 0, 8'h00, 1));
        plan.push_back(cfg_row(CFG_MAX_PACKET, 0));
        plan.push_back(cfg_row(CFG_EARLY_THRESHOLD, 0));
        plan.push_back(item_row(MODE_TX_DONE, 8'h00, 0, 8'h00, 1));
        // zero threshold and a cap of zero acting as one byte
        plan.push_back(typed_row(MODE_WRITE,   8'hA5, 1, 8'h00, 1, 1, 1, 3, 1, 255, 0, 0));
        plan.push_back(item_row(MODE_WRITE,   8'h5A, 1, 8'h00, 1));
        // transmit done with the link down drops what is buffered
        plan.push_back(typed_row(MODE_TX_DONE, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0, 0, 1, 0));
        plan.push_back(cfg_row(CFG_MAX_PACKET, 255));
        plan.push_back(cfg_row(CFG_EARLY_THRESHOLD, 511));
        plan.push_back(cfg_row(CFG_LATENCY_FRAMES, 255));
        plan.push_back(item_row(MODE_WRITE,   8'h81, 1, 8'h00, 1));
        plan.push_back(item_row(MODE_TX_DONE, 8'h00, 1, 8'h00, 1));
        plan.push_back(item_row(MODE_READ,    8'h00, 0, 8'h04, 1));

        // hold reset, then release it at a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                push_beat(plan[i].it, plan[i].typed, plan[i].want);
        end

        // Random phases: each sets all three registers (listed values first, then
        // random values), then runs write bursts, transmit-done events, tick
        // runs, reads and some noise.
        for (int p = 0; p < PHASES; p++) begin
            calm = (p == 1 || p == 6);
            if (p < 5) begin
                write_reg(CFG_MAX_PACKET, pmax[p]);
                write_reg(CFG_EARLY_THRESHOLD, pthr[p]);
                write_reg(CFG_LATENCY_FRAMES, plat[p]);
            end else begin
                write_reg(CFG_MAX_PACKET, $urandom_range(0, 255));
                write_reg(CFG_EARLY_THRESHOLD, $urandom_range(0, 511));
                write_reg(CFG_LATENCY_FRAMES, $urandom_range(0, 255));
            end
            sent = 0;
            while (sent < PHASE_BEATS) begin
                r = $urandom_range(0, 99);
                it = '0;
                if (r < 2) begin
                    // let every expected result beat come back before going on
                    wait_idle();
                end else if (r < 50) begin
                    // write burst; long ones can push the ring to full
                    if ($urandom_range(0, 99) < ((cfg_thr > 200) ? 25 : 5))
                        n = $urandom_range(200, 300);
                    else
                        n = $urandom_range(1, 24);
                    // keep the phase close to its beat budget
                    if (n > PHASE_BEATS - sent) n = PHASE_BEATS - sent;
                    k = ($urandom_range(0, 19) != 0);
                    for (int b = 0; b < n; b++) begin
                        it.mode       = MODE_WRITE;
                        it.data_byte  = 8'($urandom_range(0, 255));
                        it.last_byte  = (b == n - 1);
                        it.read_index = 8'($urandom_range(0, 255));
                        it.link_ready = k;
                        send_random(it);
                    end
                    sent += n;
                end else if (r < 65) begin
                    it.mode       = MODE_TX_DONE;
                    it.data_byte  = 8'($urandom_range(0, 255));
                    it.last_byte  = 1'($urandom_range(0, 1));
                    it.link_ready = ($urandom_range(0, 99) < 85);
                    send_random(it);
                    sent++;
                end else if (r < 80) begin
                    // tick run, now and then long enough to hit the latency
                    n = ($urandom_range(0, 9) == 0) ? cfg_lat + 1 : $urandom_range(1, 4);
                    if (n > PHASE_BEATS - sent) n = PHASE_BEATS - sent;
                    for (int b = 0; b < n; b++) begin
                        it.mode       = MODE_TICK;
                        it.link_ready = 1'($urandom_range(0, 1));
                        it.last_byte  = 1'($urandom_range(0, 1));
                        send_random(it);
                    end
                    sent += n;
                end else begin
                    // reads of stored bytes, or a beat with every field random
                    it.mode       = (r < 90) ? MODE_READ : 2'($urandom_range(0, 3));
                    it.data_byte  = 8'($urandom_range(0, 255));
                    it.last_byte  = 1'($urandom_range(0, 1));
                    it.link_ready = 1'($urandom_range(0, 1));
                    if (it.mode == MODE_READ && !any_written) it.mode = MODE_TICK;
                    it.read_index = (it.mode == MODE_READ) ? pick_read_index()
                                                           : 8'($urandom_range(0, 255));
                    send_random(it);
                    sent++;
                end
            end
        end

        // drain, allow the two-stage pipe to settle, then judge
        wait_idle();
        repeat (10) @(negedge i_clk);
        if (errors == 0)
            $display("tx_ring_packetizer_tb OK");
        else
            $display("tx_ring_packetizer_tb NOT OK");
        $finish;
    end

endmodule
